// File: sv/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared sizes, character codes, text type and fraction digit helper for the
// 16.16 fixed-point to decimal text formatter.
// ----------------------------------------------------------------------------
package fdt_pkg;

  localparam int WHOLE_DIGITS    = 6;
  localparam int FRACTION_DIGITS = 4;
  localparam int TEXT_LEN        = 2 + WHOLE_DIGITS + FRACTION_DIGITS;

  localparam logic [3:0] LAST_POS  = 4'(TEXT_LEN - 1);
  localparam logic [3:0] POINT_POS = 4'(1 + WHOLE_DIGITS);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // reciprocal multipliers, exact for any 16-bit dividend
  localparam logic [16:0] RECIP_10    = 17'd52429;
  localparam int          SHIFT_10    = 19;
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          SHIFT_100   = 23;
  localparam logic [16:0] RECIP_1000  = 17'd67109;
  localparam int          SHIFT_1000  = 26;
  localparam logic [16:0] RECIP_10000 = 17'd107375;
  localparam int          SHIFT_10000 = 30;

  localparam logic [12:0] FRAC_WEIGHT [4] = '{13'd6553, 13'd655, 13'd65, 13'd7};

  typedef logic [7:0] char_t;
  typedef logic [TEXT_LEN-1:0][7:0] text_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [15:0] rem;
  } frac_res_t;

  // digit = min(9, rem / wt), remainder reduced by wt * digit
  function automatic frac_res_t frac_step(input logic [15:0] rem, input logic [12:0] wt);
    frac_res_t   res;
    logic [16:0] prod;
    res.digit = 4'd0;
    res.rem   = rem;
    for (int k = 1; k <= 9; k++) begin
      prod = 17'(k) * {4'b0, wt};
      if ({1'b0, rem} >= prod) begin
        res.digit = 4'(k);
        res.rem   = rem - prod[15:0];
      end
    end
    return res;
  endfunction

endpackage

// File: sv/fdt_if.sv
// ----------------------------------------------------------------------------
// fdt_in_if / fdt_out_if
// Valid/ready channels carrying the fixed-point input value and one text
// character per transaction.
// ----------------------------------------------------------------------------
interface fdt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fixed_value;

  modport source (output valid, output fixed_value, input ready);
  modport sink   (input valid, input fixed_value, output ready);
endinterface

interface fdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic [3:0] char_position;
  logic       last_char;

  modport source (output valid, output character, output char_position,
                  output last_char, input ready);
  modport sink   (input valid, input character, input char_position,
                  input last_char, output ready);
endinterface

// File: sv/fdt_convert.sv
// ----------------------------------------------------------------------------
// fdt_convert
// Two-stage pipeline turning a 16.16 value into the full text line:
// quotients and leading fraction digits first, then characters.
// ----------------------------------------------------------------------------
module fdt_convert (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [31:0]   in_value,
  output logic          txt_valid,
  input  logic          txt_ready,
  output fdt_pkg::text_t txt
);
  import fdt_pkg::*;

  // stage a
  logic        a_vld_r;
  logic        a_neg_r;
  logic [15:0] a_whole_r;
  logic [12:0] a_q1_r;
  logic [9:0]  a_q2_r;
  logic [6:0]  a_q3_r;
  logic [2:0]  a_q4_r;
  logic [3:0]  a_fd0_r;
  logic [3:0]  a_fd1_r;
  logic [15:0] a_frem_r;

  logic        neg;
  logic [15:0] whole;
  logic [15:0] frac;
  logic [32:0] prod1, prod2, prod3, prod4;
  frac_res_t   fs0, fs1;

  // stage b
  logic        b_vld_r;
  text_t       txt_r;
  logic        b_take;

  logic [3:0]  dig  [WHOLE_DIGITS];
  logic        nz   [WHOLE_DIGITS];
  logic [WHOLE_DIGITS-1:0] mark;
  logic        placed;
  frac_res_t   fs2, fs3;
  logic [3:0]  fd   [4];
  text_t       txt_nxt;

  function automatic logic [3:0] low_digit(input logic [15:0] n, input logic [15:0] q);
    logic [15:0] t;
    t = n - ((q << 3) + (q << 1));
    return t[3:0];
  endfunction

  assign b_take   = a_vld_r && (!b_vld_r || txt_ready);
  assign in_ready = !a_vld_r || b_take;

  always_comb begin
    neg   = in_value[31];
    whole = neg ? ~in_value[31:16] : in_value[31:16];
    frac  = neg ? ~in_value[15:0]  : in_value[15:0];
    prod1 = {17'b0, whole} * {16'b0, RECIP_10};
    prod2 = {17'b0, whole} * {16'b0, RECIP_100};
    prod3 = {17'b0, whole} * {16'b0, RECIP_1000};
    prod4 = {17'b0, whole} * {16'b0, RECIP_10000};
    fs0   = frac_step(frac, FRAC_WEIGHT[0]);
    fs1   = frac_step(fs0.rem, FRAC_WEIGHT[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_vld_r <= in_valid;
      end
      if (!b_vld_r || txt_ready) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_neg_r   <= neg;
      a_whole_r <= whole;
      a_q1_r    <= 13'(prod1 >> SHIFT_10);
      a_q2_r    <= 10'(prod2 >> SHIFT_100);
      a_q3_r    <= 7'(prod3 >> SHIFT_1000);
      a_q4_r    <= 3'(prod4 >> SHIFT_10000);
      a_fd0_r   <= fs0.digit;
      a_fd1_r   <= fs1.digit;
      a_frem_r  <= fs1.rem;
    end
    if (b_take) begin
      txt_r <= txt_nxt;
    end
  end

  always_comb begin
    dig[0] = low_digit(a_whole_r, 16'(a_q1_r));
    dig[1] = low_digit(16'(a_q1_r), 16'(a_q2_r));
    dig[2] = low_digit(16'(a_q2_r), 16'(a_q3_r));
    dig[3] = low_digit(16'(a_q3_r), 16'(a_q4_r));
    dig[4] = 4'(a_q4_r);
    nz[0]  = 1'b1;
    nz[1]  = (a_q1_r != '0);
    nz[2]  = (a_q2_r != '0);
    nz[3]  = (a_q3_r != '0);
    nz[4]  = (a_q4_r != '0);
    for (int k = 5; k < WHOLE_DIGITS; k++) begin
      dig[k] = 4'd0;
      nz[k]  = 1'b0;
    end

    // first blank left of the digits, never the leftmost whole slot
    mark = '0;
    for (int k = 1; k <= WHOLE_DIGITS - 2; k++) begin
      mark[k] = a_neg_r && !nz[k] && nz[k-1];
    end
    placed = |mark;

    txt_nxt    = '0;
    txt_nxt[0] = (a_neg_r && !placed) ? CH_MINUS : CH_SPACE;
    for (int k = 0; k < WHOLE_DIGITS; k++) begin
      if (mark[k]) begin
        txt_nxt[WHOLE_DIGITS-k] = CH_MINUS;
      end else if (nz[k]) begin
        txt_nxt[WHOLE_DIGITS-k] = CH_ZERO + 8'(dig[k]);
      end else begin
        txt_nxt[WHOLE_DIGITS-k] = CH_SPACE;
      end
    end
    txt_nxt[1+WHOLE_DIGITS] = CH_POINT;

    fs2   = frac_step(a_frem_r, FRAC_WEIGHT[2]);
    fs3   = frac_step(fs2.rem, FRAC_WEIGHT[3]);
    fd[0] = a_fd0_r;
    fd[1] = a_fd1_r;
    fd[2] = fs2.digit;
    fd[3] = fs3.digit;
    for (int j = 0; j < FRACTION_DIGITS; j++) begin
      txt_nxt[2+WHOLE_DIGITS+j] = CH_ZERO + 8'(fd[j]);
    end
  end

  assign txt_valid = b_vld_r;
  assign txt       = txt_r;

endmodule

// File: sv/fix16_to_decimal_text.sv
// ----------------------------------------------------------------------------
// fix16_to_decimal_text
// Formats a signed 16.16 value as fixed-width ASCII text, one character per
// output transaction.
// ----------------------------------------------------------------------------
// Each accepted value produces TEXT_LEN characters (12 with six whole and four
// fraction digits): a sign slot, the whole part right-justified with leading
// spaces, '.', then the fraction digits, positions counted from 0 and the
// final one flagged by last_char. Negative inputs are shown as the one's
// complement of both halves, with '-' in the blank just left of the digits, or
// in the sign slot when that blank would be the leftmost whole slot. The input
// rate is set by the character serialiser, which sends one character per
// cycle while the output is not stalled. Two formatting stages and the text
// buffer let the next value be taken while the current line is still being
// sent. A value passes stage a, stage b, the shift register and the output
// register before its first character appears.
module fix16_to_decimal_text (
  input  logic        clk,
  input  logic        rst_n,
  fdt_in_if.sink      in_chan,
  fdt_out_if.source   out_chan
);
  import fdt_pkg::*;

  logic       txt_valid;
  logic       txt_ready;
  text_t      txt;

  logic       sh_vld_r;
  text_t      sh_r;
  logic [3:0] pos_r;
  logic       sh_last;
  logic       ld_out;

  logic       out_vld_r;
  char_t      out_char_r;
  logic [3:0] out_pos_r;
  logic       out_last_r;

  fdt_convert u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_value  ($unsigned(in_chan.fixed_value)),
    .txt_valid (txt_valid),
    .txt_ready (txt_ready),
    .txt       (txt)
  );

  assign sh_last   = (pos_r == LAST_POS);
  assign ld_out    = sh_vld_r && (!out_vld_r || out_chan.ready);
  assign txt_ready = !sh_vld_r || (ld_out && sh_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_vld_r  <= 1'b0;
      pos_r     <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (txt_valid && txt_ready) begin
        sh_vld_r <= 1'b1;
        pos_r    <= 4'd0;
      end else if (ld_out) begin
        pos_r <= pos_r + 4'd1;
        if (sh_last) begin
          sh_vld_r <= 1'b0;
        end
      end
      if (ld_out) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (txt_valid && txt_ready) begin
      sh_r <= txt;
    end else if (ld_out) begin
      sh_r <= {CH_SPACE, sh_r[TEXT_LEN-1:1]};
    end
    if (ld_out) begin
      out_char_r <= sh_r[0];
      out_pos_r  <= pos_r;
      out_last_r <= sh_last;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.character     = out_char_r;
  assign out_chan.char_position = out_pos_r;
  assign out_chan.last_char     = out_last_r;

endmodule

// File: sv/fdt_checker.sv
// ----------------------------------------------------------------------------
// fdt_checker
// Port-level checks on the character stream of the decimal text formatter.
// ----------------------------------------------------------------------------
module fdt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic [3:0] out_char_position,
  input logic       out_last_char
);
  import fdt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) &&
      $stable(out_char_position) && $stable(out_last_char))
    else $error("stalled character changed");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_char == (out_char_position == LAST_POS)))
    else $error("last flag does not match final position");

  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_position == POINT_POS |-> out_character == CH_POINT)
    else $error("missing decimal point");

  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_position > POINT_POS |->
      out_character >= CH_ZERO && out_character <= CH_NINE)
    else $error("fraction character is not a digit");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_char |=>
      !out_valid || out_char_position == $past(out_char_position) + 4'd1)
    else $error("character positions out of order");

endmodule

bind fix16_to_decimal_text fdt_checker u_fdt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_character     (out_chan.character),
  .out_char_position (out_chan.char_position),
  .out_last_char     (out_chan.last_char)
);
